FILE: hdl/intra_route_local_search_macros.svh
// Assertion macros for the intra-route local search block.
// Included by the RTL files that carry assertions; depends on clk and rst_n.
`ifndef INTRA_ROUTE_LOCAL_SEARCH_MACROS_SVH
`define INTRA_ROUTE_LOCAL_SEARCH_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define IRLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define IRLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IRLS_ASSERT_NOW(lbl, ante, cons)
`define IRLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/irls_pkg.sv
// Package for the intra-route local search block: sizes, codes, move tables.
// No dependencies.
`default_nettype none
package irls_pkg;

  localparam int NUM_VERTICES        = 256;
  localparam int MAX_ROUTE_POSITIONS = 32;
  localparam int WEIGHT_BITS         = 16;

  localparam int VTX_BITS  = $clog2(NUM_VERTICES);
  localparam int POS_BITS  = $clog2(MAX_ROUTE_POSITIONS);
  localparam int IDX_W     = POS_BITS + 2;
  localparam int GAIN_W    = WEIGHT_BITS + POS_BITS + 2;
  localparam int TOTAL_W   = 21;
  localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;
  localparam int WT_DEPTH  = NUM_VERTICES * NUM_VERTICES;
  localparam int RT_DEPTH  = 2 * MAX_ROUTE_POSITIONS;
  localparam int RT_AW     = POS_BITS + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef enum logic [1:0] {
    OP_LOAD_W = 2'd0,
    OP_LOAD_R = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MK_SWAP11  = 3'd0,
    MK_SWAP12  = 3'd1,
    MK_SWAP22  = 3'd2,
    MK_REINS1  = 3'd3,
    MK_REINS2  = 3'd4,
    MK_TWO_OPT = 3'd5
  } move_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_T_P, S_T_Q, S_T_W, S_T_A, S_CAND_END,
    S_PASS_END, S_CP_RD, S_CP_WR, S_EM_RD, S_EM_OUT
  } state_t;

  // one arc term of a gain sum
  typedef struct packed {
    logic valid;
    logic neg;
    logic persist;
    idx_t p;
    idx_t q;
  } term_t;

  function automatic idx_t blk_n1(logic [2:0] kind);
    return (kind == MK_SWAP22 || kind == MK_REINS2) ? idx_t'(2) : idx_t'(1);
  endfunction

  function automatic idx_t blk_n2(logic [2:0] kind);
    return (kind == MK_SWAP11) ? idx_t'(1) : idx_t'(2);
  endfunction

  function automatic logic cand_ok(logic [2:0] kind, idx_t i, idx_t j, logic ph,
                                   idx_t last);
    idx_t n1, n2;
    logic ok;
    n1 = blk_n1(kind);
    n2 = blk_n2(kind);
    ok = 1'b0;
    case (kind)
      MK_SWAP11, MK_SWAP12, MK_SWAP22: begin
        if (!ph)
          ok = (n1 != n2) && (j >= idx_t'(1)) && (j + n2 - idx_t'(1) < i) &&
               (i + n1 - idx_t'(1) <= last);
        else
          ok = (j >= i + n1) && (j + n2 - idx_t'(1) <= last) &&
               (i + n1 - idx_t'(1) <= last);
      end
      MK_REINS1, MK_REINS2: begin
        ok = ph && (i + n1 - idx_t'(1) <= last) && (j <= last) &&
             !((j + idx_t'(1) >= i) && (j <= i + n1 - idx_t'(1)));
      end
      MK_TWO_OPT: ok = ph && (j > i) && (j <= last) && (i + idx_t'(1) <= last);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic term_t mk_term(logic v, logic n, logic ps, idx_t p, idx_t q);
    term_t r;
    r.valid = v; r.neg = n; r.persist = ps; r.p = p; r.q = q;
    return r;
  endfunction

  function automatic term_t term_of(logic [2:0] kind, idx_t i, idx_t j, logic ph,
                                    logic [2:0] t);
    idx_t x, y, nx, ny, n;
    logic adj, first;
    term_t r;
    r = '0;
    if (!ph) begin
      x = j; y = i; nx = blk_n2(kind); ny = blk_n1(kind);
    end else begin
      x = i; y = j; nx = blk_n1(kind); ny = blk_n2(kind);
    end
    adj   = (x + nx == y);
    n     = blk_n1(kind);
    first = (j == i + idx_t'(1));
    case (kind)
      MK_SWAP11, MK_SWAP12, MK_SWAP22: begin
        case (t)
          3'd0: r = mk_term(1'b1, 1'b0, 1'b0, x - idx_t'(1), x);
          3'd1: r = mk_term(1'b1, 1'b0, 1'b0, y - idx_t'(1), y);
          3'd2: r = mk_term(1'b1, 1'b0, 1'b0, y + ny - idx_t'(1), y + ny);
          3'd3: r = mk_term(1'b1, 1'b1, 1'b0, x - idx_t'(1), y);
          3'd4: r = mk_term(1'b1, 1'b1, 1'b0, x + nx - idx_t'(1), y + ny);
          3'd5: r = adj ? mk_term(1'b1, 1'b1, 1'b0, y + ny - idx_t'(1), x)
                        : mk_term(1'b1, 1'b0, 1'b0, x + nx - idx_t'(1), x + nx);
          3'd6: r = mk_term(!adj, 1'b1, 1'b0, y - idx_t'(1), x);
          default: r = mk_term(!adj, 1'b1, 1'b0, y + ny - idx_t'(1), x + nx);
        endcase
      end
      MK_REINS1, MK_REINS2: begin
        case (t)
          3'd0: r = mk_term(1'b1, 1'b0, 1'b0, i - idx_t'(1), i);
          3'd1: r = mk_term(1'b1, 1'b0, 1'b0, i + n - idx_t'(1), i + n);
          3'd2: r = mk_term(1'b1, 1'b0, 1'b0, j, j + idx_t'(1));
          3'd3: r = mk_term(1'b1, 1'b1, 1'b0, i - idx_t'(1), i + n);
          3'd4: r = mk_term(1'b1, 1'b1, 1'b0, j, i);
          3'd5: r = mk_term(1'b1, 1'b1, 1'b0, i + n - idx_t'(1), j + idx_t'(1));
          default: r = '0;
        endcase
      end
      MK_TWO_OPT: begin
        case (t)
          3'd0: r = mk_term(first, 1'b0, 1'b1, i - idx_t'(1), i);
          3'd1: r = mk_term(first, 1'b0, 1'b1, i, i + idx_t'(1));
          3'd2: r = mk_term(1'b1, 1'b0, 1'b1, j, j + idx_t'(1));
          3'd3: r = mk_term(1'b1, 1'b1, 1'b1, j, j - idx_t'(1));
          3'd4: r = mk_term(1'b1, 1'b1, 1'b0, i - idx_t'(1), j);
          3'd5: r = mk_term(1'b1, 1'b1, 1'b0, i, j + idx_t'(1));
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // old position that feeds new position k after applying the chosen move
  function automatic idx_t src_of(logic [2:0] kind, idx_t bi, idx_t bj, logic bph,
                                  idx_t k);
    idx_t x, y, a, b, n, r;
    r = k;
    if (!bph) begin
      x = bj; y = bi; a = blk_n2(kind); b = blk_n1(kind);
    end else begin
      x = bi; y = bj; a = blk_n1(kind); b = blk_n2(kind);
    end
    n = blk_n1(kind);
    case (kind)
      MK_SWAP11, MK_SWAP12, MK_SWAP22: begin
        if (k < x)               r = k;
        else if (k < x + b)      r = y + (k - x);
        else if (k < y + b - a)  r = (k - b) + a;
        else if (k < y + b)      r = x + ((k + a) - (y + b));
        else                     r = k;
      end
      MK_REINS1, MK_REINS2: begin
        if (bi > bj) begin
          if (k <= bj)                      r = k;
          else if (k < bj + idx_t'(1) + n)  r = bi + (k - bj - idx_t'(1));
          else if (k < bi + n)              r = k - n;
          else                              r = k;
        end else begin
          if (k < bi)                       r = k;
          else if (k + n < bj + idx_t'(1))  r = k + n;
          else if (k <= bj)                 r = bi + ((k + n) - (bj + idx_t'(1)));
          else                              r = k;
        end
      end
      MK_TWO_OPT: r = (k >= bi && k <= bj) ? (bi + bj) - k : k;
      default:    r = k;
    endcase
    return r;
  endfunction

  function automatic logic vtx_bad(logic [7:0] v);
    return int'(v) >= NUM_VERTICES;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/irls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module irls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/intra_route_local_search.sv
// Top level of the intra-route local search block: sequencer and datapath.
// Depends on irls_pkg, irls_ram and intra_route_local_search_macros.svh.
//
//  channel  handshake            payload
//  input    start & !busy        in_operation .. in_route_len
//  result   out_valid (strobe)   out_position, out_vertex, out_total_gain, out_last
//
// Load items are taken while idle; busy stays low.
// A run walks every candidate (i, ph, j); for a real candidate each arc term
// steps through route read, route read, weight read and accumulate, and an
// unused term slot is skipped. An improving pass copies all 32 positions of
// the live half of the route store into the other half through the RAM.
// Emission reads and then outputs each position; results cannot be stalled.
// Reset (rst_n, synchronous) clears state, bank, total and best only.
`default_nettype none
module intra_route_local_search
  import irls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_operation,
  input  wire logic [7:0]          in_from_vertex,
  input  wire logic [7:0]          in_to_vertex,
  input  wire logic [15:0]         in_weight,
  input  wire logic [4:0]          in_position,
  input  wire logic [7:0]          in_route_vertex,
  input  wire logic [2:0]          in_move_kind,
  input  wire logic [5:0]          in_route_len,
  output logic                     out_valid,
  output logic [4:0]               out_position,
  output logic [7:0]               out_vertex,
  output logic [TOTAL_W-1:0]       out_total_gain,
  output logic                     out_last
);

  state_t state_r, state_nxt;

  // enumeration and term counters
  idx_t       i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic       ph_r, ph_nxt;
  logic [2:0] t_r, t_nxt;
  logic [2:0] kind_r, kind_nxt;
  idx_t       last_r, last_nxt;     // len - 2
  logic       bank_r, bank_nxt;     // which half of the route RAM is live

  gain_t g_r, g_nxt, run_r, run_nxt, best_r, best_nxt;
  idx_t  bi_r, bi_nxt, bj_r, bj_nxt;
  logic  bph_r, bph_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [7:0] va_r, va_nxt;
  logic       bad_r, bad_nxt;

  // memories
  logic                  rt_we;
  logic [RT_AW-1:0]      rt_waddr, rt_raddr;
  logic [7:0]            rt_wdata, rt_rdata;
  logic                  wt_we;
  logic [2*VTX_BITS-1:0] wt_waddr, wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;

  irls_ram #(.WIDTH(8), .DEPTH(RT_DEPTH)) u_route (
    .clk, .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rdata)
  );

  irls_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WT_DEPTH)) u_weight (
    .clk, .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  logic  accept, cand, enum_end, k_end, cp_end;
  term_t term;
  idx_t  src;
  gain_t arc;
  logic [GAIN_W:0] tsum;
  logic [6:0] len_sat;

  assign accept   = start && !busy;
  assign cand     = cand_ok(kind_r, i_r, j_r, ph_r, last_r);
  assign enum_end = (j_r == last_r) && ph_r && (i_r == last_r);
  assign k_end    = (k_r == last_r + idx_t'(1));
  // the copy covers the whole store so positions past the route survive
  assign cp_end   = (k_r == idx_t'(MAX_ROUTE_POSITIONS - 1));
  assign term     = term_of(kind_r, i_r, j_r, ph_r, t_r);
  assign src      = src_of(kind_r, bi_r, bj_r, bph_r, k_r);
  assign arc      = bad_r ? '0 : gain_t'(wt_rdata);
  assign tsum     = (GAIN_W+1)'(total_r) + (GAIN_W+1)'(unsigned'(best_r));

  always_comb begin
    if (in_route_len < 6'd3) len_sat = 7'd3;
    else if (int'(in_route_len) > MAX_ROUTE_POSITIONS) len_sat = 7'(MAX_ROUTE_POSITIONS);
    else len_sat = {1'b0, in_route_len};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (accept && in_operation == OP_RUN) state_nxt = S_NEXT;
      S_NEXT: begin
        if (cand)          state_nxt = S_T_P;
        else if (enum_end) state_nxt = S_PASS_END;
      end
      S_T_P: begin
        if (term.valid)       state_nxt = S_T_Q;
        else if (t_r == 3'd7) state_nxt = S_CAND_END;
      end
      S_T_Q:      state_nxt = S_T_W;
      S_T_W:      state_nxt = S_T_A;
      S_T_A:      state_nxt = (t_r == 3'd7) ? S_CAND_END : S_T_P;
      S_CAND_END: state_nxt = enum_end ? S_PASS_END : S_NEXT;
      S_PASS_END: state_nxt = (best_r > 0) ? S_CP_RD : S_EM_RD;
      S_CP_RD:    state_nxt = S_CP_WR;
      S_CP_WR:    state_nxt = cp_end ? S_NEXT : S_CP_RD;
      S_EM_RD:    state_nxt = S_EM_OUT;
      S_EM_OUT:   state_nxt = k_end ? S_IDLE : S_EM_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    i_nxt = i_r; j_nxt = j_r; ph_nxt = ph_r; t_nxt = t_r; k_nxt = k_r;
    kind_nxt = kind_r; last_nxt = last_r; bank_nxt = bank_r;
    g_nxt = g_r; run_nxt = run_r; best_nxt = best_r;
    bi_nxt = bi_r; bj_nxt = bj_r; bph_nxt = bph_r;
    total_nxt = total_r; va_nxt = va_r; bad_nxt = bad_r;

    // candidate walk: i outer, then block order, then j
    if ((state_r == S_NEXT && !cand) || state_r == S_CAND_END) begin
      if (j_r != last_r) j_nxt = j_r + idx_t'(1);
      else begin
        j_nxt = '0;
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          i_nxt  = i_r + idx_t'(1);
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept && in_operation == OP_RUN) begin
          kind_nxt  = in_move_kind;
          last_nxt  = idx_t'(len_sat - 7'd2);
          i_nxt     = idx_t'(1);
          j_nxt     = '0;
          ph_nxt    = 1'b0;
          best_nxt  = '0;
          total_nxt = '0;
        end
      end
      S_NEXT: begin
        if (cand) begin
          t_nxt = '0;
          if (kind_r == MK_TWO_OPT && j_r != i_r + idx_t'(1)) g_nxt = run_r;
          else g_nxt = '0;
          if (kind_r == MK_TWO_OPT && j_r == i_r + idx_t'(1)) run_nxt = '0;
        end
      end
      S_T_P: if (!term.valid) t_nxt = t_r + 3'd1;
      S_T_Q: va_nxt = rt_rdata;
      S_T_W: bad_nxt = vtx_bad(va_r) || vtx_bad(rt_rdata);
      S_T_A: begin
        g_nxt = term.neg ? g_r - arc : g_r + arc;
        if (term.persist) run_nxt = term.neg ? run_r - arc : run_r + arc;
        t_nxt = t_r + 3'd1;
      end
      S_CAND_END: begin
        if (g_r > best_r) begin
          best_nxt = g_r; bi_nxt = i_r; bj_nxt = j_r; bph_nxt = ph_r;
        end
      end
      S_PASS_END: begin
        k_nxt = '0;
        if (best_r > 0)
          total_nxt = (tsum > (GAIN_W+1)'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                      : TOTAL_W'(tsum);
      end
      S_CP_WR: begin
        k_nxt = k_r + idx_t'(1);
        if (cp_end) begin
          bank_nxt = !bank_r;
          i_nxt    = idx_t'(1);
          j_nxt    = '0;
          ph_nxt   = 1'b0;
          best_nxt = '0;
        end
      end
      S_EM_OUT: k_nxt = k_r + idx_t'(1);
      default: ;
    endcase
  end

  // memory controls and outputs
  always_comb begin
    rt_we    = 1'b0;
    rt_waddr = {bank_r, in_position[POS_BITS-1:0]};
    rt_wdata = in_route_vertex;
    rt_raddr = {bank_r, k_r[POS_BITS-1:0]};
    wt_we    = accept && in_operation == OP_LOAD_W &&
               !vtx_bad(in_from_vertex) && !vtx_bad(in_to_vertex);
    wt_waddr = {VTX_BITS'(in_from_vertex), VTX_BITS'(in_to_vertex)};
    wt_wdata = WEIGHT_BITS'(in_weight);
    wt_raddr = {VTX_BITS'(va_r), VTX_BITS'(rt_rdata)};
    case (state_r)
      S_IDLE:
        rt_we = accept && in_operation == OP_LOAD_R &&
                int'(in_position) < MAX_ROUTE_POSITIONS;
      S_T_P:   rt_raddr = {bank_r, term.p[POS_BITS-1:0]};
      S_T_Q:   rt_raddr = {bank_r, term.q[POS_BITS-1:0]};
      S_CP_RD: rt_raddr = {bank_r, src[POS_BITS-1:0]};
      S_CP_WR: begin
        rt_we    = 1'b1;
        rt_waddr = {!bank_r, k_r[POS_BITS-1:0]};
        rt_wdata = rt_rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    busy           = (state_r != S_IDLE);
    out_valid      = (state_r == S_EM_OUT);
    out_position   = 5'(k_r);
    out_vertex     = rt_rdata;
    out_last       = k_end;
    out_total_gain = k_end ? total_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      total_r <= '0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      total_r <= total_nxt;
      best_r  <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; ph_r <= ph_nxt; t_r <= t_nxt; k_r <= k_nxt;
    kind_r <= kind_nxt; last_r <= last_nxt;
    g_r <= g_nxt; run_r <= run_nxt;
    bi_r <= bi_nxt; bj_r <= bj_nxt; bph_r <= bph_nxt;
    va_r <= va_nxt; bad_r <= bad_nxt;
  end

`include "intra_route_local_search_macros.svh"
  `IRLS_ASSERT_NOW(a_out_busy, out_valid, busy)
  `IRLS_ASSERT_NEXT(a_out_gap, out_valid && !out_last, !out_valid)
  `IRLS_ASSERT_NEXT(a_bank_flip, state_r == S_CP_WR && cp_end, bank_r != $past(bank_r))
  `IRLS_ASSERT_NOW(a_best_pos, busy, !best_r[GAIN_W-1])
  `IRLS_ASSERT_NEXT(a_last_idle, out_valid && out_last, !busy)

endmodule
`default_nettype wire
